>>> sv/pid_position_hold_macros.svh
// assertion macros shared by the pid position hold rtl
// expects clk and arst_n in scope where used
`ifndef PID_POSITION_HOLD_MACROS_SVH
`define PID_POSITION_HOLD_MACROS_SVH

// same-cycle implication, disabled in reset
`define PPH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define PPH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pph_pkg.sv
// package for the pid position hold block: widths, codes and the microcode rom
// no dependencies
`timescale 1ns / 1ps

package pph_pkg;

	// field widths
	localparam int ANGLE_W         = 16;
	localparam int ERR_W           = ANGLE_W + 1;
	localparam int GAIN_W          = 16;
	localparam int DEADBAND_W      = 15;
	localparam int DUTY_W          = 7;
	localparam int OUT_W           = 8;
	localparam int DIR_W           = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int ANGLE_FRAC_BITS = 6;

	// parameter defaults
	localparam int ACCUM_WIDTH_DEF    = 24;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd100;

	// drive direction codes
	localparam logic [DIR_W-1:0] DIR_COAST   = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_DERIV_GAIN = 3'd3,
		REG_DUTY_LIMIT = 3'd4
	} reg_idx_t;

	// microprogram addressing
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_CHECK   = 4'd0;
	localparam pc_t STEP_MUL_P   = 4'd1;
	localparam pc_t STEP_ADD_P   = 4'd2;
	localparam pc_t STEP_SAT_I   = 4'd3;
	localparam pc_t STEP_CLAMP_I = 4'd4;
	localparam pc_t STEP_MUL_I   = 4'd5;
	localparam pc_t STEP_ADD_I   = 4'd6;
	localparam pc_t STEP_MUL_D   = 4'd7;
	localparam pc_t STEP_ADD_D   = 4'd8;
	localparam pc_t STEP_CLAMP_S = 4'd9;
	localparam pc_t STEP_FINISH  = 4'd10;
	localparam pc_t STEP_COAST   = 4'd11;

	// datapath operation of one step
	typedef enum logic [2:0] {
		OP_CHECK   = 3'd0,
		OP_MUL     = 3'd1,
		OP_ADD     = 3'd2,
		OP_SAT_I   = 3'd3,
		OP_CLAMP_I = 3'd4,
		OP_CLAMP_S = 3'd5,
		OP_FINISH  = 3'd6,
		OP_COAST   = 3'd7
	} op_t;

	// multiplier operand pair
	typedef enum logic [1:0] {
		MS_ERR   = 2'd0,
		MS_INTEG = 2'd1,
		MS_DERR  = 2'd2
	} mul_sel_t;

	// jump conditions
	typedef enum logic [1:0] {
		JC_NONE     = 2'd0,
		JC_INBAND   = 2'd1,
		JC_NO_INTEG = 2'd2,
		JC_NO_DERIV = 2'd3
	} jmp_cond_t;

	typedef struct packed {
		op_t       op;
		mul_sel_t  mul_sel;
		jmp_cond_t cond;
		pc_t       target;
	} ucode_t;

	// control store
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			STEP_CHECK:   w = '{OP_CHECK,   MS_ERR,   JC_INBAND,   STEP_COAST};
			STEP_MUL_P:   w = '{OP_MUL,     MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_ADD_P:   w = '{OP_ADD,     MS_ERR,   JC_NO_INTEG, STEP_MUL_D};
			STEP_SAT_I:   w = '{OP_SAT_I,   MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_CLAMP_I: w = '{OP_CLAMP_I, MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_MUL_I:   w = '{OP_MUL,     MS_INTEG, JC_NONE,     STEP_CHECK};
			STEP_ADD_I:   w = '{OP_ADD,     MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_MUL_D:   w = '{OP_MUL,     MS_DERR,  JC_NO_DERIV, STEP_CLAMP_S};
			STEP_ADD_D:   w = '{OP_ADD,     MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_CLAMP_S: w = '{OP_CLAMP_S, MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_FINISH:  w = '{OP_FINISH,  MS_ERR,   JC_NONE,     STEP_CHECK};
			STEP_COAST:   w = '{OP_COAST,   MS_ERR,   JC_NONE,     STEP_CHECK};
			default:      w = '{OP_COAST,   MS_ERR,   JC_NONE,     STEP_CHECK};
		endcase
		return w;
	endfunction

endpackage

>>> sv/pph_div.sv
// restoring unsigned divider, one quotient bit per cycle
// standalone; widths come from the instantiating module
`timescale 1ns / 1ps

module pph_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[DEN_W+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

>>> sv/pid_position_hold.sv
// pid position hold controller with deadband and integral anti-windup
// uses pph_pkg, pph_div and pid_position_hold_macros.svh
//
// usage:
//  - item channel (item_valid/item_ready) carries target_angle and measured_angle,
//    signed 1/64 degree; result channel (result_valid/result_ready) carries
//    signed_output, drive_dir and drive_pct
//  - cfg_we/cfg_index/cfg_data writes a register; write only while idle
//  - one item is worked at a time by a microcoded sequencer over a shared
//    multiplier and accumulator; item_ready is high whenever no item is in work
//  - an error inside the deadband goes from the check step straight to coast;
//    otherwise the proportional term is added, then the integral term when
//    integ_gain is nonzero, its clamp waiting on the restoring divider for the
//    windup bound, one quotient bit per cycle; the derivative add is skipped
//    when deriv_gain is zero or no earlier item has finished
//  - a new item is taken only once the last one leaves work; the output register
//    holds a result while the next item is taken and worked
//  - a stalled receiver holds the sequencer at its last step until the
//    pending result transfers
//  - reset clears state and integral, sets duty_limit to 100, gains to 0
`timescale 1ns / 1ps
`include "pid_position_hold_macros.svh"

module pid_position_hold
	import pph_pkg::*;
#(
	parameter int ACCUM_WIDTH    = ACCUM_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic signed [ANGLE_W-1:0]  target_angle,
	input  logic signed [ANGLE_W-1:0]  measured_angle,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [OUT_W-1:0]    signed_output,
	output logic [DIR_W-1:0]           drive_dir,
	output logic [DUTY_W-1:0]          drive_pct,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int SCALE_BITS = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
	localparam int NUM_W      = DUTY_W + SCALE_BITS;
	localparam int MUL_A_W    = NUM_W + 1;
	localparam int PROD_W     = MUL_A_W + GAIN_W + 1;
	localparam int TERM_W     = ERR_W + 1 + GAIN_W;
	localparam int SUM_W      = ((TERM_W > NUM_W + 1) ? TERM_W : NUM_W + 1) + 2;
	localparam int CMP_W      = ((ACCUM_WIDTH > NUM_W) ? ACCUM_WIDTH : NUM_W) + 2;

	// configuration registers
	logic [DEADBAND_W-1:0] deadband_q;
	logic [GAIN_W-1:0]     prop_gain_q;
	logic [GAIN_W-1:0]     integ_gain_q;
	logic [GAIN_W-1:0]     deriv_gain_q;
	logic [DUTY_W-1:0]     duty_limit_q;

	// sequencer and state
	logic                         busy_q;
	pc_t                          pc_q;
	logic signed [ERR_W-1:0]      err_q;
	logic signed [ERR_W-1:0]      last_err_q;
	logic                         primed_q;
	logic signed [ACCUM_WIDTH-1:0] integ_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [SUM_W-1:0]      acc_q;

	// result register
	logic                     result_valid_q;
	logic signed [OUT_W-1:0]  signed_output_q;
	logic [DIR_W-1:0]         drive_dir_q;
	logic [DUTY_W-1:0]        drive_pct_q;

	ucode_t                    uc;
	logic [ERR_W-1:0]          err_mag;
	logic                      inband;
	logic                      jump;
	logic                      last_step;
	logic                      stall;
	logic                      step_go;
	logic                      div_done;
	logic [NUM_W-1:0]          div_quot;
	logic [NUM_W-1:0]          lim_u;
	logic signed [ERR_W:0]     derr;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0]         mul_b;
	logic signed [ACCUM_WIDTH:0] isum;
	logic signed [ACCUM_WIDTH-1:0] isat;
	logic signed [CMP_W-1:0]   icmp;
	logic signed [CMP_W-1:0]   ilim_c;
	logic signed [CMP_W-1:0]   iclamp;
	logic signed [SUM_W-1:0]   lim_s;
	logic signed [SUM_W-1:0]   sclamp;
	logic [SUM_W-1:0]          acc_mag;
	logic [DUTY_W-1:0]         pct;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= '0;
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			duty_limit_q <= DUTY_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEADBAND:   deadband_q   <= cfg_data[DEADBAND_W-1:0];
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DUTY_LIMIT: duty_limit_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// control word of the current step
	assign uc = ucode_rom(pc_q);

	// deadband test
	assign err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign inband  = err_mag <= ERR_W'(deadband_q);

	// jump conditions
	always_comb begin
		unique case (uc.cond)
			JC_NONE:     jump = 1'b0;
			JC_INBAND:   jump = inband;
			JC_NO_INTEG: jump = integ_gain_q == '0;
			JC_NO_DERIV: jump = (deriv_gain_q == '0) || !primed_q;
			default:     jump = 1'b0;
		endcase
	end

	// step advance, held for the divider or a full result register
	assign last_step = (uc.op == OP_FINISH) || (uc.op == OP_COAST);
	assign stall     = ((uc.op == OP_CLAMP_I) && !div_done) ||
	                   (last_step && result_valid_q && !result_ready);
	assign step_go   = busy_q && !stall;
	assign item_ready = !busy_q;

	// windup bound divider: (duty_limit << scale) / integ_gain
	assign lim_u = {duty_limit_q, {SCALE_BITS{1'b0}}};

	pph_div #(
		.NUM_W (NUM_W),
		.DEN_W (GAIN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_go && (uc.op == OP_CHECK)),
		.numer  (lim_u),
		.denom  (integ_gain_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// shared multiplier operands
	assign derr = (ERR_W+1)'(err_q) - (ERR_W+1)'(last_err_q);

	always_comb begin
		case (uc.mul_sel)
			MS_ERR: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = prop_gain_q;
			end
			MS_INTEG: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = integ_gain_q;
			end
			MS_DERR: begin
				mul_a = MUL_A_W'(derr);
				mul_b = deriv_gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// integral saturating add
	assign isum = (ACCUM_WIDTH+1)'(integ_q) + (ACCUM_WIDTH+1)'(err_q);
	always_comb begin
		if (isum[ACCUM_WIDTH] != isum[ACCUM_WIDTH-1]) begin
			isat = isum[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
			                        : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
		end else begin
			isat = isum[ACCUM_WIDTH-1:0];
		end
	end

	// integral clamp to the windup bound
	assign icmp   = CMP_W'(integ_q);
	assign ilim_c = $signed({{(CMP_W-NUM_W){1'b0}}, div_quot});
	always_comb begin
		if (icmp > ilim_c) begin
			iclamp = ilim_c;
		end else if (icmp < -ilim_c) begin
			iclamp = -ilim_c;
		end else begin
			iclamp = icmp;
		end
	end

	// sum clamp to the duty limit
	assign lim_s = $signed({{(SUM_W-NUM_W){1'b0}}, lim_u});
	always_comb begin
		if (acc_q > lim_s) begin
			sclamp = lim_s;
		end else if (acc_q < -lim_s) begin
			sclamp = -lim_s;
		end else begin
			sclamp = acc_q;
		end
	end

	// magnitude truncated toward zero
	assign acc_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign pct     = acc_mag[SCALE_BITS +: DUTY_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_CHECK;
		end else if (item_valid && item_ready) begin
			busy_q <= 1'b1;
			pc_q   <= STEP_CHECK;
		end else if (step_go) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end
			pc_q <= jump ? uc.target : pc_q + 1'b1;
		end
	end

	// controller state kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_err_q <= '0;
			primed_q   <= 1'b0;
		end else if (step_go) begin
			case (uc.op)
				OP_SAT_I:   integ_q <= isat;
				OP_CLAMP_I: integ_q <= iclamp[ACCUM_WIDTH-1:0];
				OP_FINISH: begin
					last_err_q <= err_q;
					primed_q   <= 1'b1;
				end
				OP_COAST:   last_err_q <= err_q;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			err_q <= ERR_W'(target_angle) - ERR_W'(measured_angle);
		end
		if (step_go) begin
			case (uc.op)
				OP_CHECK:   acc_q  <= '0;
				OP_MUL:     prod_q <= mul_a * $signed({1'b0, mul_b});
				OP_ADD:     acc_q  <= acc_q + SUM_W'(prod_q);
				OP_CLAMP_S: acc_q  <= sclamp;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_go && last_step) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && (uc.op == OP_COAST)) begin
			signed_output_q <= '0;
			drive_dir_q     <= DIR_COAST;
			drive_pct_q     <= '0;
		end else if (step_go && (uc.op == OP_FINISH)) begin
			drive_pct_q <= pct;
			if (acc_q == '0) begin
				signed_output_q <= '0;
				drive_dir_q     <= DIR_COAST;
			end else if (acc_q[SUM_W-1]) begin
				signed_output_q <= -$signed({1'b0, pct});
				drive_dir_q     <= DIR_REVERSE;
			end else begin
				signed_output_q <= $signed({1'b0, pct});
				drive_dir_q     <= DIR_FORWARD;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign signed_output = signed_output_q;
	assign drive_dir     = drive_dir_q;
	assign drive_pct     = drive_pct_q;

	// checks
	`PPH_ASSERT_NXT(a_accept_starts, item_valid && item_ready, busy_q && (pc_q == STEP_CHECK), "accepted item did not start the program")
	`PPH_ASSERT_NXT(a_div_wait_holds, busy_q && (uc.op == OP_CLAMP_I) && !div_done, busy_q && $stable(pc_q), "sequencer left the divider wait early")
	`PPH_ASSERT_IMP(a_coast_zero, result_valid && (drive_dir == DIR_COAST), (drive_pct == '0) && (signed_output == '0), "coast result carries drive")

endmodule
